@@ rtl/core/ptsp_pkg.sv @@
package ptsp_pkg;

    // operation codes (s_tuser)
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_ADV = 2'd1;
    localparam logic [1:0] OP_SEL = 2'd2;

    // shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    localparam int DEF_TASK_SLOTS = 16;

    localparam int ID_W      = 8;
    localparam int PERIOD_W  = 20;
    localparam int INC_W     = 16;
    localparam int ELAPSED_W = 31;
    localparam int WORD_W    = 32;
    localparam int OUT_SLOT_W = 4;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;

    localparam logic signed [WORD_W-1:0] SLACK_FLOOR = -32'sd99999;
    localparam logic [ELAPSED_W-1:0]     ELAPSED_MAX = 31'h7FFF_FFFF;

    // table write enables
    typedef struct packed {
        logic entry;    // whole entry: id, period, elapsed cleared
        logic elapsed;  // elapsed count only
    } tbl_we_t;

endpackage

@@ rtl/core/ptsp_table.sv @@
module ptsp_table #(
    parameter int TASK_SLOTS = ptsp_pkg::DEF_TASK_SLOTS,
    parameter int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  logic                             aclk,
    input  ptsp_pkg::tbl_we_t                we,
    input  logic [SLOT_W-1:0]                waddr,
    input  logic [ptsp_pkg::ID_W-1:0]        wr_id,
    input  logic [ptsp_pkg::PERIOD_W-1:0]    wr_period,
    input  logic [ptsp_pkg::ELAPSED_W-1:0]   wr_elapsed,
    input  logic [SLOT_W-1:0]                raddr,
    output logic [ptsp_pkg::ID_W-1:0]        rd_id,
    output logic [ptsp_pkg::PERIOD_W-1:0]    rd_period,
    output logic [ptsp_pkg::ELAPSED_W-1:0]   rd_elapsed
);
    import ptsp_pkg::*;

    logic [ID_W-1:0]      id_mem      [TASK_SLOTS];
    logic [PERIOD_W-1:0]  period_mem  [TASK_SLOTS];
    logic [ELAPSED_W-1:0] elapsed_mem [TASK_SLOTS];

    always_ff @(posedge aclk) begin
        if (we.entry) begin
            id_mem[waddr]     <= wr_id;
            period_mem[waddr] <= wr_period;
        end
        if (we.entry || we.elapsed) begin
            elapsed_mem[waddr] <= wr_elapsed;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_id      <= id_mem[raddr];
        rd_period  <= period_mem[raddr];
        rd_elapsed <= elapsed_mem[raddr];
    end

endmodule

@@ rtl/core/ptsp_alu.sv @@
module ptsp_alu (
    input  logic                                 op,
    input  logic [ptsp_pkg::WORD_W-1:0]          a,
    input  logic [ptsp_pkg::WORD_W-1:0]          b,
    input  logic signed [ptsp_pkg::WORD_W-1:0]   best,
    output logic [ptsp_pkg::WORD_W-1:0]          res,
    output logic [ptsp_pkg::ELAPSED_W-1:0]       sat,
    output logic                                 gt
);
    import ptsp_pkg::*;

    always_comb begin
        res = (op == ALU_SUB) ? (a - b) : (a + b);
        // sum of a 31-bit count and a 16-bit step never reaches 2^32
        sat = res[WORD_W-1] ? ELAPSED_MAX : res[ELAPSED_W-1:0];
        gt  = $signed(res) > best;
    end

endmodule

@@ rtl/core/periodic_task_slack_picker_top.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: operation; s_tdata: id, period, increment
// m_        out  m_tvalid/m_tready  m_tdata: add_ok, is_idle, slot, id, slack, now_ms
//
// add_task and unused codes: accept moves to the done state, where the result register loads.
// advance_time and select_next: one slot per cycle through the registered table read
// and the shared add/subtract unit; the block returns to idle when the result loads,
// and only then is the next request taken.
// aresetn (synchronous, active low) clears task count, clock and valid; table undefined.
// A waiting result holds the next finished request in the done state; no new request is taken until it loads.
module periodic_task_slack_picker_top #(
    parameter int TASK_SLOTS = ptsp_pkg::DEF_TASK_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] task_id, [27:8] period_ms, [43:28] increment_ms, [47:44] zero
    input  logic [ptsp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  logic [ptsp_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] add_ok, [1] is_idle, [5:2] selected_slot, [13:6] selected_id,
    // [45:14] selected_slack, [77:46] now_ms, [79:78] zero
    output logic [ptsp_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import ptsp_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [WORD_W-1:0]       time_reg, time_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    pend_reg, pend_next;
    logic [SLOT_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [1:0]              op_reg, op_next;
    logic [INC_W-1:0]        inc_reg, inc_next;
    logic                    add_ok_reg, add_ok_next;
    logic                    found_reg, found_next;
    logic signed [WORD_W-1:0] best_slack_reg, best_slack_next;
    logic [SLOT_W-1:0]       best_slot_reg, best_slot_next;
    logic [ID_W-1:0]         best_id_reg, best_id_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg, m_data_next;

    tbl_we_t                 tbl_we;
    logic [SLOT_W-1:0]       tbl_waddr;
    logic [ELAPSED_W-1:0]    tbl_wel;
    logic [ID_W-1:0]         rd_id;
    logic [PERIOD_W-1:0]     rd_period;
    logic [ELAPSED_W-1:0]    rd_elapsed;

    logic                    alu_op;
    logic [WORD_W-1:0]       alu_b;
    logic [WORD_W-1:0]       alu_res;
    logic [ELAPSED_W-1:0]    alu_sat;
    logic                    alu_gt;

    logic                    accept;
    logic                    walk_end;
    logic                    finish;
    logic                    load;
    logic                    is_sel;
    logic                    sel_hit;

    ptsp_table #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_table (
        .aclk       (aclk),
        .we         (tbl_we),
        .waddr      (tbl_waddr),
        .wr_id      (s_tdata[ID_W-1:0]),
        .wr_period  (s_tdata[ID_W +: PERIOD_W]),
        .wr_elapsed (tbl_wel),
        .raddr      (rd_idx_reg[SLOT_W-1:0]),
        .rd_id      (rd_id),
        .rd_period  (rd_period),
        .rd_elapsed (rd_elapsed)
    );

    ptsp_alu u_alu (
        .op   (alu_op),
        .a    ({1'b0, rd_elapsed}),
        .b    (alu_b),
        .best (best_slack_reg),
        .res  (alu_res),
        .sat  (alu_sat),
        .gt   (alu_gt)
    );

    // select: slack = elapsed - period; advance: elapsed + increment
    assign alu_op = (op_reg == OP_SEL) ? ALU_SUB : ALU_ADD;
    assign alu_b  = (op_reg == OP_SEL) ? WORD_W'(rd_period) : WORD_W'(inc_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign walk_end = (state_reg == ST_WALK) && (rd_idx_reg >= count_reg) && !pend_reg;
    assign finish   = walk_end || (state_reg == ST_DONE);
    assign load     = finish && (!m_valid_reg || m_tready);

    // result assembly; fields outside their operation read zero
    assign is_sel  = (op_reg == OP_SEL);
    assign sel_hit = is_sel && found_reg;

    always_comb begin
        m_data_next = '0;
        m_data_next[0]     = (op_reg == OP_ADD) && add_ok_reg;
        m_data_next[1]     = is_sel && !found_reg;
        m_data_next[5:2]   = sel_hit ? OUT_SLOT_W'(best_slot_reg) : '0;
        m_data_next[13:6]  = sel_hit ? best_id_reg : '0;
        m_data_next[45:14] = sel_hit ? best_slack_reg : '0;
        m_data_next[77:46] = time_reg;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        op_next         = op_reg;
        inc_next        = inc_reg;
        add_ok_next     = add_ok_reg;
        found_next      = found_reg;
        best_slack_next = best_slack_reg;
        best_slot_next  = best_slot_reg;
        best_id_next    = best_id_reg;
        tbl_we          = '0;
        tbl_waddr       = pend_idx_reg;
        tbl_wel         = alu_sat;

        if (accept) begin
            op_next         = s_tuser;
            inc_next        = s_tdata[ID_W+PERIOD_W +: INC_W];
            rd_idx_next     = '0;
            pend_next       = 1'b0;
            add_ok_next     = 1'b0;
            found_next      = 1'b0;
            best_slack_next = SLACK_FLOOR;
            unique case (s_tuser)
                OP_ADD: begin
                    if (count_reg < CNT_W'(TASK_SLOTS)) begin
                        tbl_we.entry = 1'b1;
                        tbl_waddr    = count_reg[SLOT_W-1:0];
                        tbl_wel      = '0;
                        count_next   = count_reg + CNT_W'(1);
                        add_ok_next  = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                OP_ADV: begin
                    time_next  = time_reg + WORD_W'(s_tdata[ID_W+PERIOD_W +: INC_W]);
                    state_next = ST_WALK;
                end
                OP_SEL: begin
                    state_next = ST_WALK;
                end
                default: begin
                    state_next = ST_DONE;
                end
            endcase
        end

        if (state_reg == ST_WALK) begin
            // issue one read per cycle, process it the cycle after
            if (rd_idx_reg < count_reg) begin
                rd_idx_next   = rd_idx_reg + CNT_W'(1);
                pend_next     = 1'b1;
                pend_idx_next = rd_idx_reg[SLOT_W-1:0];
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg) begin
                if (op_reg == OP_ADV) begin
                    tbl_we.elapsed = 1'b1;
                end else if (alu_gt) begin
                    // strict compare: ties keep the lower slot
                    found_next      = 1'b1;
                    best_slack_next = alu_res;
                    best_slot_next  = pend_idx_reg;
                    best_id_next    = rd_id;
                end
            end
            if (walk_end && !load) begin
                state_next = ST_DONE;
            end
        end

        if (load) begin
            state_next = ST_IDLE;
        end
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            time_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        pend_idx_reg   <= pend_idx_next;
        op_reg         <= op_next;
        inc_reg        <= inc_next;
        add_ok_reg     <= add_ok_next;
        found_reg      <= found_next;
        best_slack_reg <= best_slack_next;
        best_slot_reg  <= best_slot_next;
        best_id_reg    <= best_id_next;
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // table never holds more tasks than slots
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TASK_SLOTS))
        else $error("task count above slot count");

    // a successful add grows the table by one
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == OP_ADD) && (count_reg < CNT_W'(TASK_SLOTS)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("add did not grow the table");

    // an idle answer carries no selection
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> ((m_tdata[45:2] == '0) && !m_tdata[0]))
        else $error("idle result with selection fields set");

endmodule
